### hw/rtl/mlgt_pkg.sv
// ----------------------------------------------------------------------------
// MLD listener group timers package
// Shared types, codes and helper functions of the group timer block.
// ----------------------------------------------------------------------------
package mlgt_pkg;

  localparam int GROUP_SLOTS_DEF = 16;
  localparam int MAX_OUT         = 16;
  localparam int CNT_W           = 5;
  localparam int DIV_W           = 16;
  localparam int TIMER_W         = 16;
  localparam int PADDR_W         = 4;
  localparam int PDATA_W         = 32;

  localparam logic [15:0] TIMER_SCALE_MS = 16'd1000;
  localparam logic [63:0] ALLNODES_HI    = 64'hff02_0000_0000_0000;
  localparam logic [63:0] ALLNODES_LO    = 64'h1;

  // Reciprocal of 1000 scaled by 2**33, exact for products below 2**24.
  localparam logic [23:0] RECIP_1000  = 24'd8589935;
  localparam int          RECIP_SHIFT = 33;

  localparam logic [2:0] ACT_JOIN   = 3'd0;
  localparam logic [2:0] ACT_LEAVE  = 3'd1;
  localparam logic [2:0] ACT_QUERY  = 3'd2;
  localparam logic [2:0] ACT_REPORT = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;

  localparam logic [1:0] MSG_NONE   = 2'd0;
  localparam logic [1:0] MSG_REPORT = 2'd1;
  localparam logic [1:0] MSG_DONE   = 2'd2;
  localparam logic [1:0] MSG_FULL   = 2'd3;

  localparam logic [1:0] REG_TPS      = 2'd0;
  localparam logic [1:0] REG_UNSOL    = 2'd1;
  localparam logic [1:0] REG_LOOPBACK = 2'd2;
  localparam logic [1:0] REG_HLL      = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] group_addr_hi;
    logic [63:0] group_addr_lo;
    logic [15:0] max_delay_ms;
    logic        src_is_link_local;
    logic        looped_back;
    logic [15:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  msg_kind;
    logic [63:0] msg_group_hi;
    logic [63:0] msg_group_lo;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [6:0] tps;
    logic [7:0] unsol;
    logic       loopback;
    logic       hll;
  } cfg_t;

  typedef struct packed {
    logic [63:0]        hi;
    logic [63:0]        lo;
    logic [TIMER_W-1:0] timer;
    logic               flag;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV1, S_DIV1_WAIT, S_DIV2, S_DIV2_WAIT, S_READ, S_EVAL, S_FINAL, S_FLUSH
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_second;
    logic take_first;
    logic take_second;
    logic rd;
    logic eval;
    logic fin;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic scan_last;
    logic eval_stall;
    logic flush_ok;
  } sts_t;

  function automatic logic is_mcast(input logic [63:0] hi);
    return hi[63:56] == 8'hff;
  endfunction

  function automatic logic is_special(input logic [63:0] hi, input logic [63:0] lo);
    return (hi == ALLNODES_HI && lo == ALLNODES_LO) || (hi[51:48] < 4'd2);
  endfunction

endpackage

### hw/rtl/mld_listener_group_timers_top.sv
// After an item is accepted, the controller runs the divisions, a read and an evaluation
// step for each slot of the group table, the final update and the flush of the last result.
// The block takes no new item until the last result of the previous one is flushed.
// Reset clears all slot valid bits, the controller and the output register,
// and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// MLD listener group timers top level
// Configuration registers, controller and datapath of the group timer block.
// ----------------------------------------------------------------------------
module mld_listener_group_timers_top #(
  parameter int GROUP_SLOTS = mlgt_pkg::GROUP_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mlgt_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mlgt_pkg::out_item_t               out_item_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mlgt_pkg::PADDR_W-1:0]      paddr,
  input  logic [mlgt_pkg::PDATA_W-1:0]      pwdata,
  output logic [mlgt_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import mlgt_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{tps: 7'd5, unsol: 8'd10, loopback: 1'b0, hll: 1'b1};
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_TPS:      cfg_q.tps      <= pwdata[6:0];
        REG_UNSOL:    cfg_q.unsol    <= pwdata[7:0];
        REG_LOOPBACK: cfg_q.loopback <= pwdata[0];
        REG_HLL:      cfg_q.hll      <= pwdata[0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TPS:      prdata = {25'd0, cfg_q.tps};
      REG_UNSOL:    prdata = {24'd0, cfg_q.unsol};
      REG_LOOPBACK: prdata = {31'd0, cfg_q.loopback};
      REG_HLL:      prdata = {31'd0, cfg_q.hll};
      default:      prdata = '0;
    endcase
  end

  mlgt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlgt_datapath #(
    .GROUP_SLOTS (GROUP_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### hw/rtl/mlgt_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider that resolves one quotient bit per cycle and returns the
// remainder.
// ----------------------------------------------------------------------------
module mlgt_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mlgt_pkg::DIV_W-1:0] dividend_i,
  input  logic [15:0]               divisor_i,
  output logic                      busy_o,
  output logic [15:0]               rem_o
);
  import mlgt_pkg::*;

  logic [DIV_W-1:0] dq_q, dq_d;
  logic [15:0]      rem_q, rem_d;
  logic [15:0]      dvs_q, dvs_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [16:0]      shifted;
  logic             ge;

  assign shifted = {rem_q, dq_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (start_i) begin
      dq_d  = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 5'(DIV_W);
    end else if (cnt_q != 5'd0) begin
      rem_d = ge ? 16'(shifted - {1'b0, dvs_q}) : shifted[15:0];
      dq_d  = {dq_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = cnt_q != 5'd0;
  assign rem_o  = rem_q;

endmodule

### hw/rtl/mlgt_ctrl.sv
// ----------------------------------------------------------------------------
// Group timer controller
// Sequences divisions, the slot scan, the final update and the result flush.
// ----------------------------------------------------------------------------
module mlgt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mlgt_pkg::sts_t sts_i,
  output mlgt_pkg::cmd_t cmd_o
);
  import mlgt_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_DIV1;
      S_DIV1:      state_d = S_DIV1_WAIT;
      S_DIV1_WAIT: if (!sts_i.div_busy) state_d = S_DIV2;
      S_DIV2:      state_d = S_DIV2_WAIT;
      S_DIV2_WAIT: if (!sts_i.div_busy) state_d = S_READ;
      S_READ:      state_d = S_EVAL;
      S_EVAL: begin
        if (!sts_i.eval_stall) state_d = sts_i.scan_last ? S_FINAL : S_READ;
      end
      S_FINAL:     state_d = S_FLUSH;
      S_FLUSH:     if (sts_i.flush_ok) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:      cmd_o.load = in_valid_i;
      S_DIV1:      cmd_o.div_start = 1'b1;
      S_DIV1_WAIT: cmd_o.take_first = !sts_i.div_busy;
      S_DIV2: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.div_second = 1'b1;
      end
      S_DIV2_WAIT: cmd_o.take_second = !sts_i.div_busy;
      S_READ:      cmd_o.rd = 1'b1;
      S_EVAL:      cmd_o.eval = 1'b1;
      S_FINAL:     cmd_o.fin = 1'b1;
      S_FLUSH:     cmd_o.flush = 1'b1;
      default:     cmd_o = '0;
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/mlgt_datapath.sv
// ----------------------------------------------------------------------------
// Group timer datapath
// Group table memory, item registers, divider and result registers.
// ----------------------------------------------------------------------------
module mlgt_datapath #(
  parameter int GROUP_SLOTS = mlgt_pkg::GROUP_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlgt_pkg::cfg_t      cfg_i,
  input  mlgt_pkg::in_item_t  in_item_i,
  input  mlgt_pkg::cmd_t      cmd_i,
  output mlgt_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mlgt_pkg::out_item_t out_item_o
);
  import mlgt_pkg::*;

  localparam int IW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;

  entry_t mem_q [GROUP_SLOTS];
  entry_t rdata_q;
  logic [GROUP_SLOTS-1:0] valid_q, valid_d;

  logic [2:0]  act_q;
  logic [63:0] hi_q, lo_q;
  logic [15:0] maxd_q, rnd_q;
  logic        qok_q, rok_q;
  logic [15:0] d_q, bound_q, r_q;
  logic [22:0] prod_q;
  logic [IW-1:0] idx_q, free_idx_q, match_idx_q;
  logic        match_q, match_flag_q, free_found_q;
  logic [CNT_W-1:0] cnt_q;
  logic        pend_v_q;
  logic [1:0]  pend_kind_q;
  logic [63:0] pend_hi_q, pend_lo_q;
  out_item_t   out_q;
  logic        out_v_q;

  logic        div_busy;
  logic [15:0] div_rem;

  logic        unspec, special_item, out_free;
  logic        v, eq, slot_ok, want_emit, emit_go, stall;
  logic        we;
  logic [IW-1:0] waddr;
  entry_t      wdata;
  logic [14:0] unsol_prod;
  logic [46:0] d_mul;
  logic [13:0] d_quo;
  logic [15:0] d_fix;

  assign unspec       = hi_q == 64'd0 && lo_q == 64'd0;
  assign special_item = is_special(hi_q, lo_q);
  assign out_free     = !out_v_q || !out_stall_i;

  assign unsol_prod = {7'd0, cfg_i.unsol} * {8'd0, cfg_i.tps};
  assign d_mul = 47'(prod_q) * 47'(RECIP_1000);
  assign d_quo = d_mul[46:RECIP_SHIFT];
  assign d_fix = (d_quo == 14'd0 && maxd_q != 16'd0) ? 16'd1 : {2'd0, d_quo};

  mlgt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start && cmd_i.div_second),
    .dividend_i (rnd_q),
    .divisor_i  (bound_q),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // Slot evaluation during the scan and the table write of the final join update.
  always_comb begin
    v         = valid_q[idx_q];
    eq        = v && rdata_q.hi == hi_q && rdata_q.lo == lo_q;
    slot_ok   = v && !is_special(rdata_q.hi, rdata_q.lo);
    want_emit = 1'b0;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = rdata_q;
    if (cmd_i.eval) begin
      if (act_q == ACT_QUERY && qok_q && slot_ok && (unspec || eq)) begin
        if (d_q == 16'd0) begin
          want_emit   = 1'b1;
          we          = 1'b1;
          wdata.timer = '0;
          wdata.flag  = 1'b1;
        end else if (rdata_q.timer == '0 || rdata_q.timer > d_q) begin
          we          = 1'b1;
          wdata.timer = r_q;
        end
      end else if (act_q == ACT_REPORT && rok_q && eq) begin
        we          = 1'b1;
        wdata.timer = '0;
        wdata.flag  = 1'b0;
      end else if (act_q == ACT_TICK && v && rdata_q.timer != '0) begin
        we          = 1'b1;
        wdata.timer = rdata_q.timer - 16'd1;
        if (rdata_q.timer == 16'd1) begin
          want_emit  = 1'b1;
          wdata.flag = 1'b1;
        end
      end
    end else if (cmd_i.fin && act_q == ACT_JOIN && !match_q && free_found_q) begin
      we          = 1'b1;
      waddr       = free_idx_q;
      wdata.hi    = hi_q;
      wdata.lo    = lo_q;
      wdata.timer = special_item ? 16'd0 : r_q;
      wdata.flag  = !special_item;
    end
    emit_go = want_emit && cfg_i.hll && (cnt_q < CNT_W'(MAX_OUT));
    stall   = emit_go && pend_v_q && !out_free;
    if (stall) begin
      we = 1'b0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.fin && act_q == ACT_JOIN && !match_q && free_found_q) begin
      valid_d[free_idx_q] = 1'b1;
    end else if (cmd_i.fin && act_q == ACT_LEAVE && match_q) begin
      valid_d[match_idx_q] = 1'b0;
    end
  end

  assign sts_o.div_busy   = div_busy;
  assign sts_o.scan_last  = idx_q == IW'(GROUP_SLOTS - 1);
  assign sts_o.eval_stall = stall;
  assign sts_o.flush_ok   = out_free;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= in_item_i.action;
      hi_q   <= in_item_i.group_addr_hi;
      lo_q   <= in_item_i.group_addr_lo;
      maxd_q <= in_item_i.max_delay_ms;
      rnd_q  <= in_item_i.random_value;
      qok_q  <= in_item_i.src_is_link_local && !cfg_i.loopback && cfg_i.hll &&
                ((in_item_i.group_addr_hi == 64'd0 && in_item_i.group_addr_lo == 64'd0) ||
                 is_mcast(in_item_i.group_addr_hi));
      rok_q  <= in_item_i.src_is_link_local && !in_item_i.looped_back &&
                is_mcast(in_item_i.group_addr_hi);
    end
    if (cmd_i.div_start && !cmd_i.div_second) begin
      prod_q <= {7'd0, maxd_q} * {16'd0, cfg_i.tps};
    end
    if (cmd_i.take_first) begin
      d_q <= d_fix;
      if (act_q == ACT_JOIN) begin
        bound_q <= (unsol_prod == 15'd0) ? 16'd1 : {1'b0, unsol_prod};
      end else begin
        bound_q <= (d_fix == 16'd0) ? 16'd1 : d_fix;
      end
    end
    if (cmd_i.take_second) begin
      r_q <= div_rem + 16'd1;
    end
    if (cmd_i.eval && !stall) begin
      if (act_q == ACT_JOIN && !v && !free_found_q) begin
        free_idx_q <= idx_q;
      end
      if (act_q == ACT_LEAVE && eq) begin
        match_idx_q  <= idx_q;
        match_flag_q <= rdata_q.flag;
      end
    end
    if (cmd_i.eval && emit_go && !stall) begin
      pend_kind_q <= MSG_REPORT;
      pend_hi_q   <= rdata_q.hi;
      pend_lo_q   <= rdata_q.lo;
    end else if (cmd_i.fin && (act_q == ACT_JOIN || act_q == ACT_LEAVE)) begin
      pend_hi_q <= hi_q;
      pend_lo_q <= lo_q;
      pend_kind_q <= (act_q == ACT_JOIN && !free_found_q) ? MSG_FULL :
                     (act_q == ACT_JOIN) ? MSG_REPORT : MSG_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      idx_q        <= '0;
      match_q      <= 1'b0;
      free_found_q <= 1'b0;
      cnt_q        <= '0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
      out_q        <= '0;
    end else begin
      valid_q <= valid_d;
      if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (cmd_i.take_second) begin
        idx_q        <= '0;
        match_q      <= 1'b0;
        free_found_q <= 1'b0;
        cnt_q        <= '0;
        pend_v_q     <= 1'b0;
      end
      if (cmd_i.eval && !stall) begin
        idx_q <= idx_q + IW'(1);
        if ((act_q == ACT_JOIN || act_q == ACT_LEAVE) && eq) begin
          match_q <= 1'b1;
        end
        if (act_q == ACT_JOIN && !v) begin
          free_found_q <= 1'b1;
        end
        if (emit_go) begin
          cnt_q    <= cnt_q + CNT_W'(1);
          pend_v_q <= 1'b1;
          if (pend_v_q) begin
            out_v_q <= 1'b1;
            out_q   <= '{msg_kind: pend_kind_q, msg_group_hi: pend_hi_q,
                         msg_group_lo: pend_lo_q, last: 1'b0};
          end
        end
      end
      if (cmd_i.fin) begin
        if (act_q == ACT_JOIN && !match_q) begin
          pend_v_q <= !free_found_q || (!special_item && cfg_i.hll);
        end else if (act_q == ACT_LEAVE && match_q) begin
          pend_v_q <= match_flag_q && !special_item && cfg_i.hll;
        end
      end
      if (cmd_i.flush && out_free) begin
        out_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
        if (pend_v_q) begin
          out_q <= '{msg_kind: pend_kind_q, msg_group_hi: pend_hi_q,
                     msg_group_lo: pend_lo_q, last: 1'b1};
        end else begin
          out_q <= '{msg_kind: MSG_NONE, msg_group_hi: 64'd0,
                     msg_group_lo: 64'd0, last: 1'b1};
        end
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

### hw/rtl/mlgt_checker.sv
// ----------------------------------------------------------------------------
// Group timer port checker
// Port-level properties of the group timer block, bound to the top level.
// ----------------------------------------------------------------------------
module mlgt_port_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mlgt_pkg::out_item_t out_item_o
);
  import mlgt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("Stalled result changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Request accepted while a previous one is in work.");

  a_none_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.msg_kind == MSG_NONE |->
      out_item_o.last && out_item_o.msg_group_hi == 64'd0 &&
      out_item_o.msg_group_lo == 64'd0)
    else $error("Status none is not a lone zero result.");

  a_full_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.msg_kind == MSG_FULL |-> out_item_o.last)
    else $error("Table full is not the final result.");

endmodule

bind mld_listener_group_timers_top mlgt_port_checker u_mlgt_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
